/* src/tdbm_pkg.sv */
// shared constants and types of the threshold and despeckle binary map
`default_nettype none
package tdbm_pkg;

  localparam int WIDTH  = 32;
  localparam int HEIGHT = 32;

  localparam int POS_W  = 5;
  localparam int DATA_W = 8;
  localparam int COL_W  = ($clog2(WIDTH) > POS_W) ? $clog2(WIDTH) : POS_W;
  localparam int ROW_W  = ($clog2(HEIGHT) > POS_W) ? $clog2(HEIGHT) : POS_W;

  localparam int SR_LEN = 2 * WIDTH + 3;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [DATA_W-1:0] THR_RESET    = DATA_W'(128);
  localparam logic [POS_W-1:0]  LAST_COL_POS = POS_W'(WIDTH - 1);
  localparam logic [POS_W-1:0]  LAST_ROW_POS = POS_W'(HEIGHT - 1);

  typedef struct packed {
    logic              land_bit;
    logic              emit_a;
    logic              emit_b;
    logic              left_edge;
    logic              top_edge;
    logic              last;
    logic [POS_W-1:0]  col_a;
    logic [POS_W-1:0]  row;
  } queue_entry_t;

endpackage
`default_nettype wire

/* src/tdbm_front.sv */
// front end: threshold register, raster counters, end of frame flush items
`default_nettype none
module tdbm_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  input  wire logic [tdbm_pkg::DATA_W-1:0] cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [tdbm_pkg::DATA_W-1:0] height_sample_i,
  input  wire logic                       q_full_i,
  output logic                            push_o,
  output tdbm_pkg::queue_entry_t          push_entry_o
);
  import tdbm_pkg::*;

  logic [DATA_W-1:0] thr_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic              flush_q, flush_d;
  logic              accept;
  logic              has_upper;
  logic              end_col;
  logic [COL_W-1:0]  col_m1;
  logic [ROW_W-1:0]  row_m1;

  assign in_stall_o = q_full_i | flush_q;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = accept | (flush_q & ~q_full_i);

  assign end_col   = (col_q == COL_W'(WIDTH - 1));
  assign has_upper = flush_q | (row_q != '0);
  assign col_m1    = col_q - COL_W'(1);
  assign row_m1    = row_q - ROW_W'(1);

  always_comb begin
    push_entry_o.land_bit  = accept & (height_sample_i > thr_q);
    push_entry_o.emit_a    = has_upper & (col_q != '0);
    push_entry_o.emit_b    = has_upper & end_col;
    push_entry_o.left_edge = (col_q == COL_W'(1));
    push_entry_o.top_edge  = ~flush_q & (row_q == ROW_W'(1));
    push_entry_o.last      = flush_q & end_col;
    push_entry_o.col_a     = col_m1[POS_W-1:0];
    push_entry_o.row       = flush_q ? LAST_ROW_POS : row_m1[POS_W-1:0];
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    flush_d = flush_q;
    if (push_o) begin
      if (end_col) begin
        col_d = '0;
        if (flush_q) begin
          flush_d = 1'b0;
        end else if (row_q == ROW_W'(HEIGHT - 1)) begin
          row_d   = '0;
          flush_d = 1'b1;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THR_RESET;
      col_q   <= '0;
      row_q   <= '0;
      flush_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      col_q   <= col_d;
      row_q   <= row_d;
      flush_q <= flush_d;
    end
  end

endmodule
`default_nettype wire

/* src/tdbm_queue.sv */
// short fifo of classified items between front and back
`default_nettype none
module tdbm_queue (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire tdbm_pkg::queue_entry_t push_entry_i,
  output logic                        full_o,
  input  wire logic                   pop_i,
  output logic                        valid_o,
  output tdbm_pkg::queue_entry_t      pop_entry_o
);
  import tdbm_pkg::*;

  queue_entry_t      mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q;
  logic [Q_PTR_W-1:0] rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q;
  logic               do_push;
  logic               do_pop;

  assign full_o      = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o     = (cnt_q != '0);
  assign pop_entry_o = mem_q[rd_ptr_q];
  assign do_push     = push_i & ~full_o;
  assign do_pop      = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - Q_CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* src/tdbm_back.sv */
// back end: two-row shift line, neighbor check, result output register
`default_nettype none
module tdbm_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   q_valid_i,
  input  wire tdbm_pkg::queue_entry_t q_entry_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        land_o,
  output logic [tdbm_pkg::POS_W-1:0]  column_o,
  output logic [tdbm_pkg::POS_W-1:0]  row_o,
  output logic                        last_of_frame_o
);
  import tdbm_pkg::*;

  logic [SR_LEN-1:0] sr_q;
  queue_entry_t      cur_q;
  logic              pend_a_q;
  logic              pend_b_q;
  logic              out_valid_q;
  logic              land_q;
  logic [POS_W-1:0]  col_q;
  logic [POS_W-1:0]  row_q;
  logic              last_q;

  logic              out_free;
  logic              emit_now;
  logic              stage_free;
  logic              keep_a;
  logic              keep_b;
  logic              res_land;
  logic [POS_W-1:0]  res_col;
  logic              res_last;

  // center of the first emission is sr bit WIDTH+1, of the second sr bit WIDTH
  assign keep_a = sr_q[WIDTH+1] & (
      (~cur_q.top_edge & ~cur_q.left_edge & sr_q[2*WIDTH+2]) |
      (~cur_q.top_edge & sr_q[2*WIDTH+1]) |
      (~cur_q.top_edge & sr_q[2*WIDTH]) |
      (~cur_q.left_edge & sr_q[WIDTH+2]) |
      sr_q[WIDTH] |
      (~cur_q.left_edge & sr_q[2]) |
      sr_q[1] |
      sr_q[0]);

  assign keep_b = sr_q[WIDTH] & (
      (~cur_q.top_edge & sr_q[2*WIDTH+1]) |
      (~cur_q.top_edge & sr_q[2*WIDTH]) |
      sr_q[WIDTH+1] |
      sr_q[1] |
      sr_q[0]);

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign emit_now   = out_free & (pend_a_q | pend_b_q);
  assign stage_free = ~(pend_a_q | pend_b_q) | (emit_now & ~(pend_a_q & pend_b_q));
  assign pop_o      = q_valid_i & stage_free;

  assign res_land = pend_a_q ? keep_a : keep_b;
  assign res_col  = pend_a_q ? cur_q.col_a : LAST_COL_POS;
  assign res_last = ~pend_a_q & cur_q.last;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sr_q  <= {sr_q[SR_LEN-2:0], q_entry_i.land_bit};
      cur_q <= q_entry_i;
    end
    if (emit_now) begin
      land_q <= res_land;
      col_q  <= res_col;
      row_q  <= cur_q.row;
      last_q <= res_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_a_q    <= 1'b0;
      pend_b_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        pend_a_q <= q_entry_i.emit_a;
        pend_b_q <= q_entry_i.emit_b;
      end else if (emit_now) begin
        if (pend_a_q) begin
          pend_a_q <= 1'b0;
        end else begin
          pend_b_q <= 1'b0;
        end
      end
      if (emit_now) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign land_o          = land_q;
  assign column_o        = col_q;
  assign row_o           = row_q;
  assign last_of_frame_o = last_q;

endmodule
`default_nettype wire

/* src/threshold_despeckle_binary_map.sv */
// top level: threshold and isolated pixel removal over a raster frame
// throughput: one sample per cycle while the queue is not full;
//   input stalls while WIDTH flush items follow the last sample of a frame
// a pixel's result leaves through the queue, shift line and output register
// reset: threshold returns to 128, position counters and queue are cleared
`default_nettype none
module threshold_despeckle_binary_map (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [tdbm_pkg::DATA_W-1:0] land_threshold_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [tdbm_pkg::DATA_W-1:0] height_sample_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            land_o,
  output logic [tdbm_pkg::POS_W-1:0]      column_o,
  output logic [tdbm_pkg::POS_W-1:0]      row_o,
  output logic                            last_of_frame_o
);
  import tdbm_pkg::*;

  logic         q_full;
  logic         push;
  queue_entry_t push_entry;
  logic         pop;
  logic         q_valid;
  queue_entry_t pop_entry;

  assign cfg_ready_o = 1'b1;

  tdbm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (land_threshold_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .height_sample_i (height_sample_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .push_entry_o    (push_entry)
  );

  tdbm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .pop_entry_o  (pop_entry)
  );

  tdbm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_entry_i       (pop_entry),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .land_o          (land_o),
    .column_o        (column_o),
    .row_o           (row_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule
`default_nettype wire

/* dv/threshold_despeckle_binary_map_test.sv */
// self-checking testbench of the threshold and despeckle binary map
`default_nettype none
module threshold_despeckle_binary_map_test;
  import tdbm_pkg::*;

  localparam int TOTAL_SAMPLES = 350;
  localparam int CALM_SAMPLES  = 80;
  localparam int SETTLE_CYCLES = 16;

  typedef enum logic {STEP_SAMPLE, STEP_THRESHOLD} step_kind_e;
  typedef enum logic {LAND_PREDICTED, LAND_WATER} land_source_e;

  typedef struct packed {
    step_kind_e        kind;
    logic [DATA_W-1:0] value;
    land_source_e      source;
  } directed_step_t;

  typedef struct packed {
    logic             land;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic             last;
  } pixel_result_t;

  localparam directed_step_t DIRECTED_STEPS [25] = '{
    '{STEP_SAMPLE,    8'd128, LAND_WATER},
    '{STEP_SAMPLE,    8'd129, LAND_PREDICTED},
    '{STEP_SAMPLE,    8'd0,   LAND_WATER},
    '{STEP_SAMPLE,    8'd255, LAND_PREDICTED},
    '{STEP_SAMPLE,    8'd255, LAND_PREDICTED},
    '{STEP_SAMPLE,    8'd0,   LAND_WATER},
    '{STEP_THRESHOLD, 8'd0,   LAND_PREDICTED},
    '{STEP_SAMPLE,    8'd0,   LAND_WATER},
    '{STEP_SAMPLE,    8'd1,   LAND_PREDICTED},
    '{STEP_SAMPLE,    8'd0,   LAND_WATER},
    '{STEP_SAMPLE,    8'd1,   LAND_PREDICTED},
    '{STEP_SAMPLE,    8'd1,   LAND_PREDICTED},
    '{STEP_THRESHOLD, 8'd255, LAND_PREDICTED},
    '{STEP_SAMPLE,    8'd255, LAND_WATER},
    '{STEP_SAMPLE,    8'd0,   LAND_WATER},
    '{STEP_SAMPLE,    8'd255, LAND_WATER},
    '{STEP_THRESHOLD, 8'd127, LAND_PREDICTED},
    '{STEP_SAMPLE,    8'd127, LAND_WATER},
    '{STEP_SAMPLE,    8'd128, LAND_PREDICTED},
    '{STEP_SAMPLE,    8'd0,   LAND_WATER},
    '{STEP_SAMPLE,    8'd255, LAND_PREDICTED},
    '{STEP_THRESHOLD, 8'd128, LAND_PREDICTED},
    '{STEP_SAMPLE,    8'd170, LAND_PREDICTED},
    '{STEP_SAMPLE,    8'd85,  LAND_WATER},
    '{STEP_SAMPLE,    8'd0,   LAND_WATER}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [DATA_W-1:0] land_threshold_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [DATA_W-1:0] height_sample_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              land_o;
  logic [POS_W-1:0]  column_o;
  logic [POS_W-1:0]  row_o;
  logic              last_of_frame_o;

  logic              idle_on = 1'b0;
  int                stall_left = 0;
  int                samples_sent = 0;
  int                mismatches = 0;

  logic [DATA_W-1:0] threshold_now = THR_RESET;
  bit                land_map [HEIGHT][WIDTH];
  bit                water_typed [HEIGHT][WIDTH];
  int                col_pos = 0;
  int                row_pos = 0;
  pixel_result_t     expected_pixels [$];

  threshold_despeckle_binary_map i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .land_threshold_i (land_threshold_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .height_sample_i  (height_sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .land_o           (land_o),
    .column_o         (column_o),
    .row_o            (row_o),
    .last_of_frame_o  (last_of_frame_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic bit pixel_survives(int x, int y);
    if (!land_map[y][x]) return 1'b0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        if ((dx != 0 || dy != 0) && x + dx >= 0 && x + dx < WIDTH &&
            y + dy >= 0 && y + dy < HEIGHT && land_map[y + dy][x + dx]) begin
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic queue_pixel_result(int x, int y, bit last);
    pixel_result_t want;
    want.land   = water_typed[y][x] ? 1'b0 : pixel_survives(x, y);
    want.column = x[POS_W-1:0];
    want.row    = y[POS_W-1:0];
    want.last   = last;
    water_typed[y][x] = 1'b0;
    expected_pixels.push_back(want);
  endtask

  task automatic take_height(logic [DATA_W-1:0] h);
    int x;
    int y;
    x = col_pos;
    y = row_pos;
    land_map[y][x] = (h > threshold_now);
    if (y >= 1) begin
      if (x >= 1) queue_pixel_result(x - 1, y - 1, 1'b0);
      if (x == WIDTH - 1) queue_pixel_result(x, y - 1, 1'b0);
    end
    if (x == WIDTH - 1 && y == HEIGHT - 1) begin
      for (int i = 0; i < WIDTH; i++) queue_pixel_result(i, y, i == WIDTH - 1);
      col_pos = 0;
      row_pos = 0;
    end else if (x == WIDTH - 1) begin
      col_pos = 0;
      row_pos = y + 1;
    end else begin
      col_pos = x + 1;
    end
  endtask

  task automatic send_height(logic [DATA_W-1:0] h);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 6) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    height_sample_i <= h;
    do @(posedge clk_i); while (in_stall_o);
    take_height(h);
    samples_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_threshold(logic [DATA_W-1:0] value);
    wait_idle();
    cfg_valid_i      <= 1'b1;
    land_threshold_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    threshold_now = value;
  endtask

  function automatic logic [DATA_W-1:0] pick_height(int density);
    if ($urandom_range(0, 9) == 0) return DATA_W'($urandom_range(0, 255));
    if (threshold_now == 8'd255 || $urandom_range(1, 100) > density) begin
      return DATA_W'($urandom_range(0, threshold_now));
    end
    return DATA_W'($urandom_range(threshold_now + 1, 255));
  endfunction

  // output stall bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left  <= $urandom_range(0, 13);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : result_check
    pixel_result_t got;
    pixel_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{land_o, column_o, row_o, last_of_frame_o};
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected transaction: land %0b column %0d row %0d last %0b",
                   got.land, got.column, got.row, got.last);
        end
      end else begin
        want = expected_pixels.pop_front();
        if (got.land !== want.land || got.column !== want.column ||
            got.row !== want.row || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected land %0b column %0d row %0d last %0b",
                     want.land, want.column, want.row, want.last);
            $display("          actual   land %0b column %0d row %0d last %0b",
                     got.land, got.column, got.row, got.last);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int phase;
    int len;
    int density;
    phase  = 0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_on <= 1'b1;

    for (int i = 0; i < $size(DIRECTED_STEPS); i++) begin
      if (DIRECTED_STEPS[i].kind == STEP_THRESHOLD) begin
        load_threshold(DIRECTED_STEPS[i].value);
      end else begin
        if (DIRECTED_STEPS[i].source == LAND_WATER) water_typed[row_pos][col_pos] = 1'b1;
        send_height(DIRECTED_STEPS[i].value);
      end
    end

    while (samples_sent < TOTAL_SAMPLES - CALM_SAMPLES) begin
      case (phase % 4)
        0: load_threshold(8'd0);
        1: load_threshold(8'd255);
        default: load_threshold(DATA_W'($urandom_range(0, 255)));
      endcase
      case ($urandom_range(0, 4))
        0: density = 3;
        1: density = 15;
        2: density = 40;
        3: density = 70;
        default: density = 95;
      endcase
      idle_on <= ($urandom_range(0, 3) != 0);
      len = $urandom_range(60, 400);
      if (len > TOTAL_SAMPLES - CALM_SAMPLES - samples_sent) begin
        len = TOTAL_SAMPLES - CALM_SAMPLES - samples_sent;
      end
      repeat (len) send_height(pick_height(density));
      phase++;
    end

    // closing stretch without idling on either side
    idle_on <= 1'b0;
    load_threshold(DATA_W'($urandom_range(1, 254)));
    while (samples_sent < TOTAL_SAMPLES) send_height(pick_height(15));

    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
